FILE: design/lrbp_pkg.sv
// Shared constants, types and tables for the LED ring bearing pointer.
// No dependencies; every other design file but lrbp_req_if and lrbp_delay imports this package.
package lrbp_pkg;

   localparam int LED_COUNT         = 8;
   localparam int DUTY_BITS_DEFAULT = 13;
   localparam int CORDIC_STEPS      = 24;
   localparam int FULL_HUND         = 36000;

   // Pipeline latencies of the units, in cycles
   localparam int BAM_LAT  = 4;
   localparam int SC_LAT   = CORDIC_STEPS + 2;
   localparam int AT_LAT   = CORDIC_STEPS + 1;
   localparam int PROD_LAT = 3;
   localparam int DUTY_LAT = 4 + SC_LAT + 1;

   // 1e-7 degree to binary angle: v * 2^22 / 3515625, done as
   // floor(|v| * ceil(2^76 / 3515625) / 2^54), exact for |v| < 2^32
   localparam int          BAM_SHIFT = 54;
   localparam logic [54:0] BAM_RECIP =
      55'(((128'd1 << (BAM_SHIFT + 22)) + 128'd3515624) / 128'd3515625);
   localparam logic signed [32:0] KGAIN = 33'sd652032874;

   typedef logic [31:0]        bam_type;
   typedef logic signed [32:0] trig_type;
   typedef logic [15:0]        hund_type;

   function automatic hund_type led_hund(input int k);
      return hund_type'((k * FULL_HUND) / LED_COUNT);
   endfunction

   function automatic bam_type atan_bam(input logic [4:0] idx);
      bam_type r;
      unique case (idx)
         5'd0:    r = 32'h20000000;
         5'd1:    r = 32'h12E4051D;
         5'd2:    r = 32'h09FB385B;
         5'd3:    r = 32'h051111D4;
         5'd4:    r = 32'h028B0D43;
         5'd5:    r = 32'h0145D7E1;
         5'd6:    r = 32'h00A2F61E;
         5'd7:    r = 32'h00517C55;
         5'd8:    r = 32'h0028BE53;
         5'd9:    r = 32'h00145F2E;
         5'd10:   r = 32'h000A2F98;
         5'd11:   r = 32'h000517CC;
         5'd12:   r = 32'h00028BE6;
         5'd13:   r = 32'h000145F3;
         5'd14:   r = 32'h0000A2F9;
         5'd15:   r = 32'h0000517C;
         5'd16:   r = 32'h000028BE;
         5'd17:   r = 32'h0000145F;
         5'd18:   r = 32'h00000A2F;
         5'd19:   r = 32'h00000517;
         5'd20:   r = 32'h0000028B;
         5'd21:   r = 32'h00000145;
         5'd22:   r = 32'h000000A2;
         5'd23:   r = 32'h00000051;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

FILE: design/lrbp_req_if.sv
// Request channel: heading and the two positions, valid/ready handshake.
// No dependencies.
interface lrbp_req_if ();
   logic               valid;
   logic               ready;
   logic [15:0]        heading;
   logic signed [30:0] own_lat;
   logic signed [31:0] own_lon;
   logic signed [30:0] dest_lat;
   logic signed [31:0] dest_lon;

   modport source (output valid, heading, own_lat, own_lon, dest_lat, dest_lon,
                   input ready);
   modport sink (input valid, heading, own_lat, own_lon, dest_lat, dest_lon,
                 output ready);
endinterface

FILE: design/lrbp_rsp_if.sv
// Response channel: bearing and the eight LED duties, valid/ready handshake.
// Depends on lrbp_pkg for the default duty width.
interface lrbp_rsp_if import lrbp_pkg::*; #(parameter int DUTY_BITS = DUTY_BITS_DEFAULT) ();
   logic                 valid;
   logic                 ready;
   logic [15:0]          bearing;
   logic [DUTY_BITS-1:0] duty_front;
   logic [DUTY_BITS-1:0] duty_front_right;
   logic [DUTY_BITS-1:0] duty_right;
   logic [DUTY_BITS-1:0] duty_rear_right;
   logic [DUTY_BITS-1:0] duty_rear;
   logic [DUTY_BITS-1:0] duty_rear_left;
   logic [DUTY_BITS-1:0] duty_left;
   logic [DUTY_BITS-1:0] duty_front_left;

   modport source (output valid, bearing, duty_front, duty_front_right, duty_right,
                   duty_rear_right, duty_rear, duty_rear_left, duty_left,
                   duty_front_left, input ready);
   modport sink (input valid, bearing, duty_front, duty_front_right, duty_right,
                 duty_rear_right, duty_rear, duty_rear_left, duty_left,
                 duty_front_left, output ready);
endinterface

FILE: design/lrbp_delay.sv
// Enabled shift line that carries side data and valid bits beside a unit.
// No dependencies.
module lrbp_delay #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic [WIDTH-1:0] d,
   output logic [WIDTH-1:0] q
);
   logic [WIDTH-1:0] tap_ff [0:DEPTH-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) tap_ff[i] <= '0;
      end else if (en) begin
         tap_ff[0] <= d;
         for (int i = 1; i < DEPTH; i++) tap_ff[i] <= tap_ff[i-1];
      end
   end

   assign q = tap_ff[DEPTH-1];
endmodule

FILE: design/lrbp_bam_conv.sv
// Coordinate to binary angle: magnitude times a scaled reciprocal of the
// divisor, two partial products, four stages. Depends on lrbp_pkg.
module lrbp_bam_conv import lrbp_pkg::*; (
   input  logic               clock,
   input  logic               en,
   input  logic signed [33:0] v,
   output bam_type            bam
);
   logic [31:0] mag_in;
   logic [31:0] mag_ff;
   logic        sg1_ff, sg2_ff, sg3_ff;
   logic [59:0] plo_ff;
   logic [57:0] phi_ff;
   logic [85:0] sum_ff;
   bam_type     bam_ff;

   assign mag_in = v[33] ? 32'(~v + 34'd1) : v[31:0];

   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff <= mag_in;
         sg1_ff <= v[33];
         plo_ff <= 60'(mag_ff) * 60'(BAM_RECIP[27:0]);
         phi_ff <= 58'(mag_ff) * 58'(BAM_RECIP[54:28]);
         sg2_ff <= sg1_ff;
         sum_ff <= {phi_ff, 28'b0} + 86'(plo_ff);
         sg3_ff <= sg2_ff;
         // truncate toward zero, then wrap to one turn
         bam_ff <= sg3_ff ? (~sum_ff[85:BAM_SHIFT] + 32'd1) : sum_ff[85:BAM_SHIFT];
      end
   end

   assign bam = bam_ff;
endmodule

FILE: design/lrbp_sincos.sv
// Pipelined rotation CORDIC: cosine and sine of a binary angle in Q30.
// Depends on lrbp_pkg.
module lrbp_sincos import lrbp_pkg::*; (
   input  logic     clock,
   input  logic     en,
   input  bam_type  a,
   output trig_type c,
   output trig_type s
);
   localparam int N  = CORDIC_STEPS;
   localparam int ZW = 34;

   logic                 neg_ff [0:N];
   trig_type             x_ff   [0:N];
   trig_type             y_ff   [0:N];
   logic signed [ZW-1:0] z_ff   [0:N];
   trig_type             x_in   [1:N];
   trig_type             y_in   [1:N];
   logic signed [ZW-1:0] z_in   [1:N];
   bam_type              probe_in;
   bam_type              af_in;
   logic                 neg_in;
   trig_type             c_ff;
   trig_type             s_ff;

   always_comb begin
      // fold into -90..+90 degrees, negate at the end
      probe_in = a + 32'h40000000;
      neg_in   = probe_in[31];
      af_in    = neg_in ? (a + 32'h80000000) : a;
      for (int i = 0; i < N; i++) begin
         if (!z_ff[i][ZW-1]) begin
            x_in[i+1] = x_ff[i] - (y_ff[i] >>> i);
            y_in[i+1] = y_ff[i] + (x_ff[i] >>> i);
            z_in[i+1] = z_ff[i] - ZW'(atan_bam(5'(i)));
         end else begin
            x_in[i+1] = x_ff[i] + (y_ff[i] >>> i);
            y_in[i+1] = y_ff[i] - (x_ff[i] >>> i);
            z_in[i+1] = z_ff[i] + ZW'(atan_bam(5'(i)));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         neg_ff[0] <= neg_in;
         x_ff[0]   <= KGAIN;
         y_ff[0]   <= '0;
         z_ff[0]   <= {{2{af_in[31]}}, af_in};
         for (int i = 1; i <= N; i++) begin
            neg_ff[i] <= neg_ff[i-1];
            x_ff[i]   <= x_in[i];
            y_ff[i]   <= y_in[i];
            z_ff[i]   <= z_in[i];
         end
         c_ff <= neg_ff[N] ? -x_ff[N] : x_ff[N];
         s_ff <= neg_ff[N] ? -y_ff[N] : y_ff[N];
      end
   end

   assign c = c_ff;
   assign s = s_ff;
endmodule

FILE: design/lrbp_atan2.sv
// Pipelined vectoring CORDIC: binary angle of the vector (x, y).
// Depends on lrbp_pkg.
module lrbp_atan2 import lrbp_pkg::*; (
   input  logic               clock,
   input  logic               en,
   input  logic signed [33:0] x,
   input  trig_type           y,
   output bam_type            z,
   output logic               zero
);
   localparam int N = CORDIC_STEPS;
   localparam int W = 36;

   logic signed [W-1:0] x_ff [0:N];
   logic signed [W-1:0] y_ff [0:N];
   bam_type             z_ff [0:N];
   logic                zero_ff [0:N];
   logic signed [W-1:0] x_in [1:N];
   logic signed [W-1:0] y_in [1:N];
   bam_type             z_in [1:N];
   logic signed [W-1:0] xe_in;
   logic signed [W-1:0] ye_in;

   always_comb begin
      xe_in = W'(x);
      ye_in = W'(y);
      for (int i = 0; i < N; i++) begin
         if (!y_ff[i][W-1] && (y_ff[i] != '0)) begin
            x_in[i+1] = x_ff[i] + (y_ff[i] >>> i);
            y_in[i+1] = y_ff[i] - (x_ff[i] >>> i);
            z_in[i+1] = z_ff[i] + atan_bam(5'(i));
         end else begin
            x_in[i+1] = x_ff[i] - (y_ff[i] >>> i);
            y_in[i+1] = y_ff[i] + (x_ff[i] >>> i);
            z_in[i+1] = z_ff[i] - atan_bam(5'(i));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         zero_ff[0] <= (x == '0) && (y == '0);
         // left half plane: rotate by a half turn first
         if (x[33]) begin
            x_ff[0] <= -xe_in;
            y_ff[0] <= -ye_in;
            z_ff[0] <= 32'h80000000;
         end else begin
            x_ff[0] <= xe_in;
            y_ff[0] <= ye_in;
            z_ff[0] <= '0;
         end
         for (int i = 1; i <= N; i++) begin
            x_ff[i]    <= x_in[i];
            y_ff[i]    <= y_in[i];
            z_ff[i]    <= z_in[i];
            zero_ff[i] <= zero_ff[i-1];
         end
      end
   end

   assign z    = z_ff[N];
   assign zero = zero_ff[N];
endmodule

FILE: design/lrbp_duty.sv
// Duty of one LED: angular distance, angle scaling, cosine and duty scaling.
// Depends on lrbp_pkg, lrbp_sincos and lrbp_delay.
module lrbp_duty import lrbp_pkg::*; #(
   parameter int DUTY_BITS = DUTY_BITS_DEFAULT,
   parameter int LED_HUND  = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  hund_type             rel,
   output logic [DUTY_BITS-1:0] duty
);
   localparam hund_type             LED_POS   = hund_type'(LED_HUND);
   localparam logic [DUTY_BITS-1:0] DUTY_MAX  = '1;
   localparam int                   PW        = DUTY_BITS + 31;

   logic [14:0]          dist_ff;
   logic [1:0]           flg2_ff, flg3_ff, flg4_ff, flg_out;
   logic [30:0]          whole2_ff, whole3_ff;
   logic [23:0]          frac2_ff, frac3_ff;
   logic [13:0]          qest_ff;
   bam_type              ang_ff;
   logic [DUTY_BITS-1:0] duty_ff;

   hund_type             diff_in;
   logic [14:0]          dist_in;
   logic [13:0]          dl_in;
   logic [46:0]          est_in;
   logic [23:0]          rem_in;
   bam_type              ang_in;
   trig_type             cos_w, sin_w;
   logic [30:0]          clamp_in;
   logic [PW-1:0]        prod_in;
   logic [DUTY_BITS-1:0] duty_in;

   always_comb begin
      diff_in  = (rel >= LED_POS) ? (rel - LED_POS) : (LED_POS - rel);
      dist_in  = (diff_in > 16'd18000) ? 15'(16'd36000 - diff_in) : diff_in[14:0];
      dl_in    = dist_ff[13:0];
      // d * 2^32 / 36000 = d * 119304 + floor(d * 728 / 1125)
      est_in   = 47'(frac2_ff) * 47'd7635497;
      rem_in   = frac3_ff - 24'(qest_ff) * 24'd1125;
      ang_in   = 32'(whole3_ff) + 32'(qest_ff) + 32'(rem_in >= 24'd1125);
      if (cos_w[32]) begin
         clamp_in = '0;
      end else if (cos_w[31:0] > 32'h40000000) begin
         clamp_in = 31'h40000000;
      end else begin
         clamp_in = cos_w[30:0];
      end
      prod_in = PW'(DUTY_MAX) * PW'(clamp_in);
      priority if (flg_out[1]) begin
         duty_in = DUTY_MAX;
      end else if (flg_out[0]) begin
         duty_in = '0;
      end else begin
         duty_in = prod_in[DUTY_BITS+29:30];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dist_ff   <= dist_in;
         flg2_ff   <= {dist_ff == '0, dist_ff >= 15'd9000};
         whole2_ff <= 31'(dl_in) * 31'd119304;
         frac2_ff  <= 24'(dl_in) * 24'd728;
         flg3_ff   <= flg2_ff;
         whole3_ff <= whole2_ff;
         frac3_ff  <= frac2_ff;
         qest_ff   <= est_in[46:33];
         flg4_ff   <= flg3_ff;
         ang_ff    <= ang_in;
         duty_ff   <= duty_in;
      end
   end

   lrbp_sincos u_cos (
      .clock (clock),
      .en    (en),
      .a     (ang_ff),
      .c     (cos_w),
      .s     (sin_w)
   );

   lrbp_delay #(.WIDTH(2), .DEPTH(SC_LAT)) u_flag_dly (
      .clock (clock),
      .reset (reset),
      .en    (en),
      .d     (flg4_ff),
      .q     (flg_out)
   );

   assign duty = duty_ff;
endmodule

FILE: design/led_ring_bearing_pointer.sv
// LED ring bearing pointer, top level. Uses lrbp_pkg, both channel
// interfaces, lrbp_bam_conv, lrbp_sincos, lrbp_atan2, lrbp_duty, lrbp_delay.
// Throughput: one transaction per cycle while the response is not stalled. The path
// from request acceptance to response valid runs through the four-stage
// reciprocal-multiply angle conversion and three 24-step CORDIC pipelines in series.
// A response stall freezes the pipeline.
// Reset (synchronous) clears mode to compass and empties the pipeline.
module led_ring_bearing_pointer import lrbp_pkg::*; #(
   parameter int DUTY_BITS = DUTY_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic       csr_wdata,
   lrbp_req_if.sink   req,
   lrbp_rsp_if.source rsp
);
   localparam int SIDE_LAT = BAM_LAT + SC_LAT + PROD_LAT + AT_LAT;

   function automatic trig_type mulq(input trig_type a, input trig_type b);
      logic signed [65:0] p;
      p = a * b;
      return p[62:30];
   endfunction

   // Pipeline control: advance whenever the output register is empty or being taken
   logic adv;
   logic out_valid;
   hund_type out_bearing;

   assign adv       = !out_valid || rsp.ready;
   assign req.ready = adv;

   // Mode register
   logic mode_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else if (csr_we) begin
         mode_ff <= csr_wdata;
      end
   end

   // Input stage: capture the transaction, take the longitude difference
   logic               s0_valid_ff;
   logic               s0_mode_ff;
   hund_type           s0_heading_ff;
   logic signed [30:0] s0_lat1_ff, s0_lat2_ff;
   logic signed [32:0] s0_dlon_ff;
   logic signed [32:0] dlon_in;

   assign dlon_in = {req.dest_lon[31], req.dest_lon} - {req.own_lon[31], req.own_lon};

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (adv) begin
         s0_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_mode_ff    <= mode_ff;
         s0_heading_ff <= req.heading;
         s0_lat1_ff    <= req.own_lat;
         s0_lat2_ff    <= req.dest_lat;
         s0_dlon_ff    <= dlon_in;
      end
   end

   // Coordinates to binary angles
   bam_type bam_own, bam_dest, bam_dlon;

   lrbp_bam_conv u_bam_own (
      .clock (clock), .en (adv),
      .v ({{3{s0_lat1_ff[30]}}, s0_lat1_ff}), .bam (bam_own)
   );
   lrbp_bam_conv u_bam_dest (
      .clock (clock), .en (adv),
      .v ({{3{s0_lat2_ff[30]}}, s0_lat2_ff}), .bam (bam_dest)
   );
   lrbp_bam_conv u_bam_dlon (
      .clock (clock), .en (adv),
      .v ({s0_dlon_ff[32], s0_dlon_ff}), .bam (bam_dlon)
   );

   // Sines and cosines of both latitudes and the longitude difference
   trig_type c1, s1, c2, s2, cd, sd;

   lrbp_sincos u_sc_own  (.clock (clock), .en (adv), .a (bam_own),  .c (c1), .s (s1));
   lrbp_sincos u_sc_dest (.clock (clock), .en (adv), .a (bam_dest), .c (c2), .s (s2));
   lrbp_sincos u_sc_dlon (.clock (clock), .en (adv), .a (bam_dlon), .c (cd), .s (sd));

   // Products: y = sd*c2, x = c1*s2 - s1*c2*cd, at most one multiply per path per stage
   trig_type           p1_y_ff, p1_t_ff, p1_p_ff, p1_cd_ff;
   trig_type           p2_y_ff, p2_p_ff, p2_u_ff;
   trig_type           p3_y_ff;
   logic signed [33:0] p3_x_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_y_ff  <= mulq(sd, c2);
         p1_t_ff  <= mulq(s1, c2);
         p1_p_ff  <= mulq(c1, s2);
         p1_cd_ff <= cd;
         p2_y_ff  <= p1_y_ff;
         p2_p_ff  <= p1_p_ff;
         p2_u_ff  <= mulq(p1_t_ff, p1_cd_ff);
         p3_y_ff  <= p2_y_ff;
         p3_x_ff  <= {p2_p_ff[32], p2_p_ff} - {p2_u_ff[32], p2_u_ff};
      end
   end

   // Initial bearing angle
   bam_type at_z;
   logic    at_zero;

   lrbp_atan2 u_atan (
      .clock (clock), .en (adv),
      .x (p3_x_ff), .y (p3_y_ff), .z (at_z), .zero (at_zero)
   );

   // Carry valid, mode and heading beside the trig units
   logic     side_valid, side_mode;
   hund_type side_heading;

   lrbp_delay #(.WIDTH(18), .DEPTH(SIDE_LAT)) u_side_dly (
      .clock (clock), .reset (reset), .en (adv),
      .d ({s0_valid_ff, s0_mode_ff, s0_heading_ff}),
      .q ({side_valid, side_mode, side_heading})
   );

   // Binary angle to hundredths, rounded half up; a full turn, compass mode or a zero vector gives zero
   logic [48:0] hsum_in;
   logic [16:0] h_in;
   hund_type    bearing_in;
   logic        br_valid_ff;
   hund_type    br_bearing_ff, br_heading_ff;

   always_comb begin
      hsum_in    = {17'b0, at_z} * 49'd36000 + 49'd2147483648;
      h_in       = hsum_in[48:32];
      bearing_in = (side_mode && !at_zero && (h_in < 17'd36000)) ? h_in[15:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         br_valid_ff <= 1'b0;
      end else if (adv) begin
         br_valid_ff <= side_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         br_bearing_ff <= bearing_in;
         br_heading_ff <= side_heading;
      end
   end

   // Relative direction: (bearing - heading) wrapped into one turn
   logic [17:0] rsum_in;
   hund_type    rel_in;
   logic        rl_valid_ff;
   hund_type    rl_bearing_ff, rl_rel_ff;

   always_comb begin
      rsum_in = {2'b0, br_bearing_ff} + 18'd72000 - {2'b0, br_heading_ff};
      priority if (rsum_in >= 18'd72000) begin
         rel_in = 16'(rsum_in - 18'd72000);
      end else if (rsum_in >= 18'd36000) begin
         rel_in = 16'(rsum_in - 18'd36000);
      end else begin
         rel_in = rsum_in[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rl_valid_ff <= 1'b0;
      end else if (adv) begin
         rl_valid_ff <= br_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rl_bearing_ff <= br_bearing_ff;
         rl_rel_ff     <= rel_in;
      end
   end

   // One duty unit per LED, spaced evenly clockwise from the front
   logic [DUTY_BITS-1:0] duty_w [0:LED_COUNT-1];

   for (genvar k = 0; k < LED_COUNT; k++) begin : g_led
      lrbp_duty #(.DUTY_BITS(DUTY_BITS), .LED_HUND(int'(led_hund(k)))) u_duty (
         .clock (clock), .reset (reset), .en (adv),
         .rel (rl_rel_ff), .duty (duty_w[k])
      );
   end

   // Hold valid and bearing beside the duty units; last tap is the output register
   lrbp_delay #(.WIDTH(17), .DEPTH(DUTY_LAT)) u_out_dly (
      .clock (clock), .reset (reset), .en (adv),
      .d ({rl_valid_ff, rl_bearing_ff}),
      .q ({out_valid, out_bearing})
   );

   assign rsp.valid            = out_valid;
   assign rsp.bearing          = out_bearing;
   assign rsp.duty_front       = duty_w[0];
   assign rsp.duty_front_right = duty_w[1];
   assign rsp.duty_right       = duty_w[2];
   assign rsp.duty_rear_right  = duty_w[3];
   assign rsp.duty_rear        = duty_w[4];
   assign rsp.duty_rear_left   = duty_w[5];
   assign rsp.duty_left        = duty_w[6];
   assign rsp.duty_front_left  = duty_w[7];
endmodule
